[rtl/llp_pkg.sv]
// Shared types, codes and constants for the LL(1) parser step core.
// Used by llp_front, llp_back and the top level; depends on nothing.
`default_nettype none
package llp_pkg;

  // fixed field widths
  localparam int SYM_W   = 6;
  localparam int CMD_W   = 3;
  localparam int POS_W   = 3;
  localparam int LEN_W   = 4;
  localparam int LENS_W  = 5;   // saturated to MAX_RHS, holds up to 31
  localparam int STAT_W  = 3;
  localparam int LVL_W   = 7;
  localparam int CIDX_W  = 2;
  localparam int ENTRY_W = SYM_W + 1;

  // parameter defaults
  localparam int DEF_SYMBOLS     = 64;
  localparam int DEF_RULES       = 64;
  localparam int DEF_MAX_RHS     = 8;
  localparam int DEF_STACK_DEPTH = 64;

  // commands
  localparam logic [CMD_W-1:0] CMD_TOKEN   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ENTRY   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BODY    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LENGTH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FOLLOW  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TERM    = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RESTART = 3'd6;

  // status codes
  localparam logic [STAT_W-1:0] ST_MORE     = 3'd0;
  localparam logic [STAT_W-1:0] ST_SUCCESS  = 3'd1;
  localparam logic [STAT_W-1:0] ST_HALTED   = 3'd2;
  localparam logic [STAT_W-1:0] ST_FAIL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNKNOWN  = 3'd4;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd5;
  localparam logic [STAT_W-1:0] ST_LOADED   = 3'd6;

  // configuration register indexes and reset values
  localparam logic [CIDX_W-1:0] CFG_START = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_EMPTY = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_END   = 2'd2;
  localparam logic [SYM_W-1:0] RST_START = 6'd1;
  localparam logic [SYM_W-1:0] RST_EMPTY = 6'd2;
  localparam logic [SYM_W-1:0] RST_END   = 6'd0;

  typedef enum logic [2:0] {
    K_TOKEN, K_ENTRY, K_BODY, K_LENGTH, K_FOLLOW, K_TERM, K_RESTART, K_NOP
  } kind_t;

  // classified word passed from front to back
  typedef struct packed {
    kind_t              kind;
    logic               ok;       // all indexes in range
    logic [SYM_W-1:0]   sym;
    logic [SYM_W-1:0]   col;
    logic [SYM_W-1:0]   rule;
    logic [POS_W-1:0]   pos;
    logic [LENS_W-1:0]  len;
    logic               bitv;
  } item_t;

  typedef struct packed {
    logic [SYM_W-1:0] start_sym;
    logic [SYM_W-1:0] empty_sym;
    logic [SYM_W-1:0] end_sym;
  } cfg_t;

endpackage
`default_nettype wire

[rtl/ll1_table_driven_parser_step_core.sv]
// LL(1) parser step core: front decoder and queue, back executor, config regs.
// A token's run grows with each expansion and each rule body slot; a busy back
// end or a stalled output delays the result.
// Throughput is one word per back-end run; the back end's sequencer sets it.
// Reset: synchronous; the parse and follow tables are then cleared, and no word
// is accepted until the clearing pass ends.
`default_nettype none
module ll1_table_driven_parser_step_core #(
  parameter int SYMBOLS     = llp_pkg::DEF_SYMBOLS,
  parameter int RULES       = llp_pkg::DEF_RULES,
  parameter int MAX_RHS     = llp_pkg::DEF_MAX_RHS,
  parameter int STACK_DEPTH = llp_pkg::DEF_STACK_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [llp_pkg::CMD_W-1:0]  in_command,
  input  wire logic [llp_pkg::SYM_W-1:0]  in_symbol,
  input  wire logic [llp_pkg::SYM_W-1:0]  in_column_symbol,
  input  wire logic [llp_pkg::SYM_W-1:0]  in_rule_index,
  input  wire logic [llp_pkg::POS_W-1:0]  in_position,
  input  wire logic [llp_pkg::LEN_W-1:0]  in_length,
  input  wire logic                       in_bit_value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [llp_pkg::STAT_W-1:0]      out_status,
  output logic [llp_pkg::SYM_W-1:0]       out_stack_top,
  output logic                            out_error_recorded,
  output logic [llp_pkg::LVL_W-1:0]       out_stack_level,
  input  wire logic                       cfg_write_en,
  input  wire logic [llp_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [llp_pkg::SYM_W-1:0]  cfg_data
);
  import llp_pkg::*;

  cfg_t  cfg_r;
  item_t q_item;
  logic  q_valid, q_pop, clearing;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_sym <= RST_START;
      cfg_r.empty_sym <= RST_EMPTY;
      cfg_r.end_sym   <= RST_END;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_START: cfg_r.start_sym <= cfg_data;
        CFG_EMPTY: cfg_r.empty_sym <= cfg_data;
        CFG_END:   cfg_r.end_sym   <= cfg_data;
        default: ;
      endcase
    end
  end

  llp_front #(
    .SYMBOLS (SYMBOLS),
    .RULES   (RULES),
    .MAX_RHS (MAX_RHS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .hold             (clearing),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_symbol        (in_symbol),
    .in_column_symbol (in_column_symbol),
    .in_rule_index    (in_rule_index),
    .in_position      (in_position),
    .in_length        (in_length),
    .in_bit_value     (in_bit_value),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_item           (q_item)
  );

  llp_back #(
    .SYMBOLS     (SYMBOLS),
    .RULES       (RULES),
    .MAX_RHS     (MAX_RHS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_valid            (q_valid),
    .q_pop              (q_pop),
    .q_item             (q_item),
    .clearing           (clearing),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_stack_top      (out_stack_top),
    .out_error_recorded (out_error_recorded),
    .out_stack_level    (out_stack_level)
  );

endmodule
`default_nettype wire

[rtl/llp_front.sv]
// Front end: accepts input words, decodes and range-checks them, and
// queues them in a two-entry buffer for the back end. Depends on llp_pkg.
`default_nettype none
module llp_front #(
  parameter int SYMBOLS = llp_pkg::DEF_SYMBOLS,
  parameter int RULES   = llp_pkg::DEF_RULES,
  parameter int MAX_RHS = llp_pkg::DEF_MAX_RHS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      hold,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [llp_pkg::CMD_W-1:0] in_command,
  input  wire logic [llp_pkg::SYM_W-1:0] in_symbol,
  input  wire logic [llp_pkg::SYM_W-1:0] in_column_symbol,
  input  wire logic [llp_pkg::SYM_W-1:0] in_rule_index,
  input  wire logic [llp_pkg::POS_W-1:0] in_position,
  input  wire logic [llp_pkg::LEN_W-1:0] in_length,
  input  wire logic                      in_bit_value,
  output logic                           q_valid,
  input  wire logic                      q_pop,
  output llp_pkg::item_t                 q_item
);
  import llp_pkg::*;

  item_t      dec;
  logic       sym_ok, col_ok, rule_ok, pos_ok;
  item_t      slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  // range checks
  assign sym_ok  = 32'(in_symbol) < SYMBOLS;
  assign col_ok  = 32'(in_column_symbol) < SYMBOLS;
  assign rule_ok = 32'(in_rule_index) < RULES;
  assign pos_ok  = 32'(in_position) < MAX_RHS;

  // classify the word
  always_comb begin
    dec.sym  = in_symbol;
    dec.col  = in_column_symbol;
    dec.rule = in_rule_index;
    dec.pos  = in_position;
    dec.bitv = in_bit_value;
    dec.len  = (32'(in_length) > MAX_RHS) ? LENS_W'(MAX_RHS) : LENS_W'(in_length);
    unique case (in_command)
      CMD_TOKEN:   begin dec.kind = K_TOKEN;   dec.ok = sym_ok; end
      CMD_ENTRY:   begin dec.kind = K_ENTRY;   dec.ok = sym_ok & col_ok & rule_ok; end
      CMD_BODY:    begin dec.kind = K_BODY;    dec.ok = rule_ok & pos_ok; end
      CMD_LENGTH:  begin dec.kind = K_LENGTH;  dec.ok = rule_ok; end
      CMD_FOLLOW:  begin dec.kind = K_FOLLOW;  dec.ok = sym_ok & col_ok; end
      CMD_TERM:    begin dec.kind = K_TERM;    dec.ok = sym_ok; end
      CMD_RESTART: begin dec.kind = K_RESTART; dec.ok = 1'b1; end
      default:     begin dec.kind = K_NOP;     dec.ok = 1'b1; end
    endcase
  end

  // two-entry queue
  assign in_ready = (cnt_r != 2'd2) & ~hold;
  assign push     = in_valid & in_ready;
  assign q_valid  = cnt_r != 2'd0;
  assign pop      = q_pop & q_valid;
  assign q_item   = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

[rtl/llp_back.sv]
// Back end: executes loads, restarts and tokens against the parse table,
// rule store and symbol stack, and holds the result word. Depends on llp_pkg.
`default_nettype none
module llp_back #(
  parameter int SYMBOLS     = llp_pkg::DEF_SYMBOLS,
  parameter int RULES       = llp_pkg::DEF_RULES,
  parameter int MAX_RHS     = llp_pkg::DEF_MAX_RHS,
  parameter int STACK_DEPTH = llp_pkg::DEF_STACK_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire llp_pkg::cfg_t              cfg,
  input  wire logic                       q_valid,
  output logic                            q_pop,
  input  wire llp_pkg::item_t             q_item,
  output logic                            clearing,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [llp_pkg::STAT_W-1:0]      out_status,
  output logic [llp_pkg::SYM_W-1:0]       out_stack_top,
  output logic                            out_error_recorded,
  output logic [llp_pkg::LVL_W-1:0]       out_stack_level
);
  import llp_pkg::*;

  localparam int SW    = $clog2(SYMBOLS);
  localparam int PDEP  = SYMBOLS * SYMBOLS;
  localparam int PW    = $clog2(PDEP);
  localparam int RW    = $clog2(RULES);
  localparam int BDEP  = RULES * MAX_RHS;
  localparam int BW    = $clog2(BDEP);
  localparam int LW    = $clog2(MAX_RHS + 1);
  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int CW    = $clog2(STACK_DEPTH + 1);
  localparam int LIMIT = SYMBOLS * STACK_DEPTH;
  localparam int IW    = $clog2(LIMIT + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RST1  = 9'b000000010,
    S_RDTOP = 9'b000000100,
    S_TOP   = 9'b000001000,
    S_ENT   = 9'b000010000,
    S_LEN   = 9'b000100000,
    S_BODY  = 9'b001000000,
    S_PUSH  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // memories
  logic [ENTRY_W-1:0] pe_mem [PDEP];
  logic               fl_mem [PDEP];
  logic [SYM_W-1:0]   body_mem [BDEP];
  logic [LW-1:0]      len_mem [RULES];
  logic [SYM_W-1:0]   stk_mem [STACK_DEPTH];
  logic               tflag_r [SYMBOLS];

  logic [ENTRY_W-1:0] pe_q;
  logic               fl_q;
  logic [SYM_W-1:0]   body_q, stk_q;
  logic [LW-1:0]      len_q;

  // working registers
  logic [SYM_W-1:0]  look_r, look_nxt, t_r, t_nxt, r_r, r_nxt;
  logic [LW-1:0]     i_r, i_nxt;
  logic [IW-1:0]     iter_r, iter_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              panic_r, panic_nxt, recov_r, recov_nxt;
  logic [STAT_W-1:0] rs_r, rs_nxt;
  logic [SYM_W-1:0]  rt_r, rt_nxt;
  logic              rr_r, rr_nxt;
  logic              clr_r;
  logic [PW-1:0]     clr_a_r;

  // write ports
  logic               pe_we, fl_we, body_we, len_we, stk_we, tf_we;
  logic [PW-1:0]      pf_wa, pf_ra;
  logic [ENTRY_W-1:0] pe_wd;
  logic               fl_wd;
  logic [BW-1:0]      body_wa, body_ra;
  logic [AW-1:0]      stk_wa, stk_ra;
  logic [SYM_W-1:0]   stk_wd;
  logic [RW-1:0]      len_ra;

  logic              out_free, t_ok, t_term, look_term, ent_ok;
  logic [SYM_W-1:0]  r_ent;
  logic [PW-1:0]     ld_a;

  assign clearing = clr_r;
  assign out_free = ~out_valid | out_ready;

  // table clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= 1'b1;
      clr_a_r <= '0;
    end else if (clr_r) begin
      clr_a_r <= clr_a_r + 1'b1;
      if (32'(clr_a_r) == PDEP - 1) clr_r <= 1'b0;
    end
  end

  // read addresses run from registers every cycle
  assign ld_a    = PW'(32'(q_item.sym) * SYMBOLS + 32'(q_item.col));
  assign pf_ra   = PW'(32'(stk_q) * SYMBOLS + 32'(look_r));
  assign len_ra  = RW'(pe_q[SYM_W-1:0]);
  assign body_ra = BW'(32'(r_r) * MAX_RHS + 32'(i_r) - 1);
  assign stk_ra  = AW'(cnt_r - 1'b1);
  assign pf_wa   = clr_r ? clr_a_r : ld_a;
  assign pe_wd   = clr_r ? '0 : {q_item.bitv, q_item.rule};
  assign fl_wd   = clr_r ? 1'b0 : q_item.bitv;
  assign body_wa = BW'(32'(q_item.rule) * MAX_RHS + 32'(q_item.pos));

  always_ff @(posedge clk) begin
    if (pe_we) pe_mem[pf_wa] <= pe_wd;
    pe_q <= pe_mem[pf_ra];
  end

  always_ff @(posedge clk) begin
    if (fl_we) fl_mem[pf_wa] <= fl_wd;
    fl_q <= fl_mem[pf_ra];
  end

  always_ff @(posedge clk) begin
    if (body_we) body_mem[body_wa] <= q_item.sym;
    body_q <= body_mem[body_ra];
  end

  always_ff @(posedge clk) begin
    if (len_we) len_mem[RW'(q_item.rule)] <= LW'(q_item.len);
    len_q <= len_mem[len_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_q <= stk_mem[stk_ra];
  end

  // terminal flags in flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SYMBOLS; k++) tflag_r[k] <= 1'b0;
    end else if (tf_we) begin
      tflag_r[SW'(q_item.sym)] <= q_item.bitv;
    end
  end

  assign look_term = q_item.ok & tflag_r[SW'(q_item.sym)];
  assign t_ok      = 32'(stk_q) < SYMBOLS;
  assign t_term    = t_ok & tflag_r[SW'(stk_q)];
  assign ent_ok    = pe_q[ENTRY_W-1] & (32'(t_r) < SYMBOLS);
  assign r_ent     = pe_q[SYM_W-1:0];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    look_nxt  = look_r;
    t_nxt     = t_r;
    r_nxt     = r_r;
    i_nxt     = i_r;
    iter_nxt  = iter_r;
    cnt_nxt   = cnt_r;
    panic_nxt = panic_r;
    recov_nxt = recov_r;
    rs_nxt    = rs_r;
    rt_nxt    = rt_r;
    rr_nxt    = rr_r;
    q_pop     = 1'b0;
    pe_we     = clr_r;
    fl_we     = clr_r;
    body_we   = 1'b0;
    len_we    = 1'b0;
    tf_we     = 1'b0;
    stk_we    = 1'b0;
    stk_wa    = '0;
    stk_wd    = cfg.end_sym;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid && !clr_r) begin
          q_pop     = 1'b1;
          rs_nxt    = ST_LOADED;
          rt_nxt    = '0;
          rr_nxt    = 1'b0;
          state_nxt = S_DONE;
          unique case (q_item.kind)
            K_TOKEN: begin
              if (!look_term) begin
                rs_nxt = ST_UNKNOWN;
              end else begin
                look_nxt  = q_item.sym;
                iter_nxt  = '0;
                state_nxt = S_RDTOP;
              end
            end
            K_ENTRY:  pe_we   = q_item.ok;
            K_BODY:   body_we = q_item.ok;
            K_LENGTH: len_we  = q_item.ok;
            K_FOLLOW: fl_we   = q_item.ok;
            K_TERM:   tf_we   = q_item.ok;
            K_RESTART: begin
              stk_we    = 1'b1;
              cnt_nxt   = CW'(2);
              panic_nxt = 1'b0;
              recov_nxt = 1'b0;
              state_nxt = S_RST1;
            end
            default: ;
          endcase
        end
      end
      S_RST1: begin
        stk_we    = 1'b1;
        stk_wa    = AW'(1);
        stk_wd    = cfg.start_sym;
        state_nxt = S_DONE;
      end
      S_RDTOP: begin
        if (cnt_r == '0) begin
          rs_nxt    = ST_HALTED;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_TOP;
        end
      end
      S_TOP: begin
        t_nxt = stk_q;
        if (t_term) begin
          cnt_nxt   = CW'(cnt_r - 1'b1);
          recov_nxt = 1'b0;
          state_nxt = S_DONE;
          if (stk_q == look_r) begin
            if (stk_q == cfg.end_sym) rs_nxt = panic_r ? ST_HALTED : ST_SUCCESS;
            else                      rs_nxt = ST_MORE;
          end else begin
            panic_nxt = 1'b1;
            rr_nxt    = 1'b1;
            rt_nxt    = stk_q;
            rs_nxt    = ST_FAIL;
          end
        end else begin
          state_nxt = S_ENT;
        end
      end
      S_ENT: begin
        if (!ent_ok) begin
          panic_nxt = 1'b1;
          rr_nxt    = ~recov_r;
          rt_nxt    = t_r;
          rs_nxt    = ST_FAIL;
          state_nxt = S_DONE;
          if (fl_q && (32'(t_r) < SYMBOLS)) begin
            cnt_nxt   = CW'(cnt_r - 1'b1);
            recov_nxt = 1'b0;
          end else begin
            recov_nxt = 1'b1;
          end
        end else if (32'(iter_r) >= LIMIT) begin
          rt_nxt    = t_r;
          rs_nxt    = ST_OVERFLOW;
          state_nxt = S_DONE;
        end else begin
          iter_nxt  = IW'(iter_r + 1'b1);
          cnt_nxt   = CW'(cnt_r - 1'b1);
          r_nxt     = r_ent;
          state_nxt = (32'(r_ent) < RULES) ? S_LEN : S_RDTOP;
        end
      end
      S_LEN: begin
        i_nxt     = len_q;
        state_nxt = S_BODY;
      end
      S_BODY: begin
        state_nxt = (i_r == '0) ? S_RDTOP : S_PUSH;
      end
      S_PUSH: begin
        i_nxt     = LW'(i_r - 1'b1);
        state_nxt = S_BODY;
        if (body_q != cfg.empty_sym) begin
          if (32'(cnt_r) >= STACK_DEPTH) begin
            rt_nxt    = t_r;
            rs_nxt    = ST_OVERFLOW;
            state_nxt = S_DONE;
          end else begin
            stk_we  = 1'b1;
            stk_wa  = AW'(cnt_r);
            stk_wd  = body_q;
            cnt_nxt = CW'(cnt_r + 1'b1);
          end
        end
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      panic_r <= 1'b0;
      recov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      panic_r <= panic_nxt;
      recov_r <= recov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    look_r <= look_nxt;
    t_r    <= t_nxt;
    r_r    <= r_nxt;
    i_r    <= i_nxt;
    iter_r <= iter_nxt;
    rs_r   <= rs_nxt;
    rt_r   <= rt_nxt;
    rr_r   <= rr_nxt;
  end

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_status         <= rs_r;
      out_stack_top      <= rt_r;
      out_error_recorded <= rr_r;
      out_stack_level    <= LVL_W'(cnt_r);
    end
  end

endmodule
`default_nettype wire
